@@ design/flpw_pkg.sv @@
// flpw_pkg: shared types, constants and helpers of the four-level page walk unit
// no dependencies; imported by flpw_store and four_level_page_walk_unit
`default_nettype none

package flpw_pkg;

  localparam int unsigned PADDR_W   = 52;  // physical byte address width
  localparam int unsigned LADDR_W   = 48;  // logical address width
  localparam int unsigned ENTRY_W   = 64;  // page-table entry width
  localparam int unsigned WORD_W    = 49;  // physical word address (byte address / 8)
  localparam int unsigned FRAME_W   = 40;  // frame number, bits 51:12
  localparam int unsigned LVL_IDX_W = 9;   // table index per level
  localparam int unsigned OFFSET_W  = 12;  // page offset width

  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  localparam logic [1:0] LEVEL_PML4 = 2'd0;
  localparam logic [1:0] LEVEL_PDPT = 2'd1;
  localparam logic [1:0] LEVEL_PD   = 2'd2;
  localparam logic [1:0] LEVEL_PT   = 2'd3;

  // read and write requests to the entry store
  typedef struct packed {
    logic              wr_en;
    logic [WORD_W-1:0] wr_word;
    logic              rd_en;
    logic [WORD_W-1:0] rd_word;
  } store_req_t;

  // 9-bit table index of a logical address at a walk level
  function automatic logic [LVL_IDX_W-1:0] level_index(input logic [LADDR_W-1:0] la,
                                                       input logic [1:0] lvl);
    logic [LVL_IDX_W-1:0] idx;
    case (lvl)
      LEVEL_PML4: idx = la[47:39];
      LEVEL_PDPT: idx = la[38:30];
      LEVEL_PD:   idx = la[29:21];
      LEVEL_PT:   idx = la[20:12];
      default:    idx = la[20:12];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ design/flpw_store.sv @@
// flpw_store: page-table entry memory with one write and one registered read port
// sweeps every entry to zero after reset; depends on flpw_pkg
`default_nettype none

module flpw_store #(
  parameter int unsigned STORE_INDEX_BITS = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire flpw_pkg::store_req_t        req,
  input  wire logic [flpw_pkg::ENTRY_W-1:0] wr_data,
  output logic [flpw_pkg::ENTRY_W-1:0]      rd_data,
  output logic                              clear_busy
);
  import flpw_pkg::*;

  localparam int unsigned DEPTH = 1 << STORE_INDEX_BITS;

  logic [ENTRY_W-1:0]          mem [DEPTH];
  logic [ENTRY_W-1:0]          rd_q;
  logic                        rd_oor;
  logic [STORE_INDEX_BITS-1:0] clear_idx;
  logic                        wr_in_range;
  logic                        rd_in_range;

  // words past the end of the store drop writes and read as zero
  assign wr_in_range = (req.wr_word[WORD_W-1:STORE_INDEX_BITS] == '0);
  assign rd_in_range = (req.rd_word[WORD_W-1:STORE_INDEX_BITS] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_idx  <= '0;
    end else if (clear_busy) begin
      clear_idx <= clear_idx + 1'b1;
      if (clear_idx == {STORE_INDEX_BITS{1'b1}}) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clear_idx] <= '0;
    end else if (req.wr_en && wr_in_range) begin
      mem[req.wr_word[STORE_INDEX_BITS-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q   <= mem[req.rd_word[STORE_INDEX_BITS-1:0]];
      rd_oor <= !rd_in_range;
    end
  end

  assign rd_data = rd_oor ? '0 : rd_q;

endmodule

`default_nettype wire

@@ design/four_level_page_walk_unit.sv @@
// four_level_page_walk_unit: top level of the four-level page walk unit
// depends on flpw_pkg and flpw_store
//
// usage
//   in channel (in_valid/in_ready): one word per command. cmd = write stores
//   entry_value at byte address entry_addr (bits 2:0 ignored, beyond the store
//   dropped), no result. cmd = translate walks pml4, pdpt, pd and pt from the
//   cr3 root and returns one word on out_valid/out_ready: fault and phys_addr,
//   phys_addr zero on a fault. cfg_valid/cfg_ready writes cr3, always ready;
//   write only while the unit is idle.
// timing
//   a write is stored as it is accepted. out_valid rises once a translate has
//   read the levels one after another from the entry memory, stopping at the
//   first entry that is not present. the next command is taken the cycle after
//   the walk ends: no command is taken during a walk, as the four dependent
//   memory reads of a walk are not overlapped.
// reset
//   synchronous, active high; cr3 and the entry memory go to zero, the memory
//   swept one entry a cycle over all 2**STORE_INDEX_BITS entries with in_ready low.
//   cfg writes are taken during the sweep.
// stall
//   a result waits in the output register while a new command is still taken;
//   a walk ending before that result is taken holds until out_ready frees it.
`default_nettype none

module four_level_page_walk_unit #(
  parameter int unsigned STORE_INDEX_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [flpw_pkg::PADDR_W-1:0]  cfg_data,
  // command words
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cmd,
  input  wire logic [flpw_pkg::PADDR_W-1:0]  entry_addr,
  input  wire logic [flpw_pkg::ENTRY_W-1:0]  entry_value,
  input  wire logic [flpw_pkg::LADDR_W-1:0]  logical_addr,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               fault,
  output logic [flpw_pkg::PADDR_W-1:0]       phys_addr
);
  import flpw_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic               state;
  logic [1:0]         level;
  logic [LADDR_W-1:0] la;
  logic [PADDR_W-1:0] cr3;

  store_req_t         req;
  logic [ENTRY_W-1:0] rd_data;
  logic               clear_busy;

  logic               in_accept;
  logic               present;
  logic               walk_done;
  logic               out_free;
  logic               emit;

  // root register, only frame bits are used by the walk
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cr3 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cr3 <= cfg_data;
    end
  end

  assign in_ready  = (state == ST_IDLE) && !clear_busy;
  assign in_accept = in_valid && in_ready;

  // entry most recently read is on rd_data while walking
  assign present   = rd_data[0];
  assign walk_done = !present || (level == LEVEL_PT);
  assign out_free  = !out_valid || out_ready;
  assign emit      = (state == ST_WALK) && walk_done && out_free;

  // store requests: writes come straight from the command word, reads either
  // start a walk at the root or follow the entry just read
  always_comb begin
    req.wr_en   = in_accept && (cmd == CMD_WRITE);
    req.wr_word = entry_addr[PADDR_W-1:3];
    req.rd_en   = 1'b0;
    req.rd_word = {cr3[PADDR_W-1:OFFSET_W], level_index(logical_addr, LEVEL_PML4)};
    if (in_accept && (cmd == CMD_TRANSLATE)) begin
      req.rd_en = 1'b1;
    end else if ((state == ST_WALK) && !walk_done) begin
      req.rd_en   = 1'b1;
      req.rd_word = {rd_data[PADDR_W-1:OFFSET_W], level_index(la, level + 2'd1)};
    end
  end

  flpw_store #(
    .STORE_INDEX_BITS(STORE_INDEX_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .wr_data    (entry_value),
    .rd_data    (rd_data),
    .clear_busy (clear_busy)
  );

  // walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      level <= LEVEL_PML4;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept && (cmd == CMD_TRANSLATE)) begin
            state <= ST_WALK;
            level <= LEVEL_PML4;
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else begin
            level <= level + 2'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // logical address held for the remaining levels
  always_ff @(posedge clk) begin
    if (in_accept) begin
      la <= logical_addr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      fault     <= !present;
      phys_addr <= present ? {rd_data[PADDR_W-1:OFFSET_W], la[OFFSET_W-1:0]} : '0;
    end
  end

  // a translate always starts at the top level
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (cmd == CMD_TRANSLATE)) |=> (state == ST_WALK) && (level == LEVEL_PML4))
    else $error("walk did not start at the top level");

  // a faulting result carries a zero address
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault) |-> (phys_addr == '0))
    else $error("fault result with nonzero address");

  // no result can exist before the clearing sweep ends
  assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !out_valid && (state == ST_IDLE))
    else $error("activity during store clearing");

  // levels advance one at a time while walking
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_WALK) && (level != LEVEL_PML4)) |->
      ($past(state) == ST_WALK) && (($past(level) == level) || ($past(level) + 2'd1 == level)))
    else $error("walk level skipped");

endmodule

`default_nettype wire
